[rtl/mpc_pkg.sv]
// ---------------------------------------------------------------------------
// mpc_pkg - shared definitions for the PS/2 mouse packet cursor
// Constants, register indexes and the packet struct used by all modules.
// ---------------------------------------------------------------------------
package mpc_pkg;

	// Cursor coordinate width and screen size register width.
	localparam int COORD_BITS = 13;
	localparam int SIZE_BITS  = 14;

	// Working width for signed position arithmetic: wide enough for a size,
	// a coordinate and a 9-bit delta with sign.
	localparam int CALC_W = ((SIZE_BITS > COORD_BITS) ? SIZE_BITS : COORD_BITS) + 2;

	localparam logic signed [CALC_W-1:0] ONE_C       = CALC_W'(1);
	localparam logic signed [CALC_W-1:0] COORD_MAX_C = CALC_W'((1 << COORD_BITS) - 1);

	// Bit positions inside the packet bytes.
	localparam int SYNC_BIT      = 3;
	localparam int X_SIGN_BIT    = 4;
	localparam int Y_SIGN_BIT    = 5;
	localparam int LEFT_BTN_BIT  = 0;
	localparam int FIFTH_BTN_BIT = 5;

	localparam logic [1:0] FIRST_BYTE = 2'd0;
	localparam logic [1:0] LAST_BYTE  = 2'd3;

	// Configuration register indexes and reset values.
	localparam logic CFG_SCREEN_WIDTH  = 1'b0;
	localparam logic CFG_SCREEN_HEIGHT = 1'b1;

	localparam logic [SIZE_BITS-1:0] WIDTH_RESET  = SIZE_BITS'(1024);
	localparam logic [SIZE_BITS-1:0] HEIGHT_RESET = SIZE_BITS'(768);

	// Packet state handed from the assembler to the cursor stage.
	typedef struct packed {
		logic       complete;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
	} pkt_t;

endpackage

[rtl/ps2_mouse_packet_cursor_top.sv]
// out_valid is registered: the fourth packet byte passes the input register and then
// the result register.
// Throughput: one byte per cycle unless a completed packet is held back, set by the
// input register feeding the result register through one adder and clamp per axis.
// A completed packet waits in the input register while an untaken result is held.
// Reset (arst_n, asynchronous): byte count, cursor position and valids clear,
// screen size returns to 1024 x 768.
// ---------------------------------------------------------------------------
// ps2_mouse_packet_cursor_top - PS/2 mouse packet decoder with cursor
// Gathers 4-byte mouse packets and tracks a clamped cursor position.
// ---------------------------------------------------------------------------
module ps2_mouse_packet_cursor_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [mpc_pkg::SIZE_BITS-1:0]  cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [7:0]                     rx_byte,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [mpc_pkg::COORD_BITS-1:0] cursor_x,
	output logic [mpc_pkg::COORD_BITS-1:0] cursor_y,
	output logic                           plot_white,
	output logic                           plot_green
);
	import mpc_pkg::*;

	logic [SIZE_BITS-1:0] width_q, height_q;
	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 fire, load;
	pkt_t                 pkt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SCREEN_WIDTH:  width_q  <= cfg_data;
				CFG_SCREEN_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The held byte moves on unless it completes a packet whose result has
	// nowhere to go yet.
	assign fire     = valid_s1 && (!pkt.complete || !out_valid || out_ready);
	assign load     = fire && pkt.complete;
	assign in_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	mpc_packet u_packet (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.byte_in (byte_s1),
		.pkt     (pkt)
	);

	mpc_cursor u_cursor (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (load),
		.pkt           (pkt),
		.last_byte     (byte_s1),
		.screen_width  (width_q),
		.screen_height (height_q),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.cursor_x      (cursor_x),
		.cursor_y      (cursor_y),
		.plot_white    (plot_white),
		.plot_green    (plot_green)
	);

endmodule

[rtl/mpc_packet.sv]
// ---------------------------------------------------------------------------
// mpc_packet - packet byte assembler
// Counts bytes of a 4-byte packet, drops unsynchronized first bytes and
// holds the first three bytes until the last one arrives.
// ---------------------------------------------------------------------------
module mpc_packet (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          fire,
	input  logic [7:0]    byte_in,
	output mpc_pkg::pkt_t pkt
);
	import mpc_pkg::*;

	logic [1:0] count_q;
	logic [7:0] bytes_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= FIRST_BYTE;
		end else if (fire) begin
			if (count_q == LAST_BYTE) begin
				count_q <= FIRST_BYTE;
			end else if (count_q != FIRST_BYTE || byte_in[SYNC_BIT]) begin
				count_q <= count_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && count_q != LAST_BYTE) begin
			bytes_q[count_q] <= byte_in;
		end
	end

	assign pkt.complete = (count_q == LAST_BYTE);
	assign pkt.b0       = bytes_q[0];
	assign pkt.b1       = bytes_q[1];
	assign pkt.b2       = bytes_q[2];

endmodule

[rtl/mpc_cursor.sv]
// ---------------------------------------------------------------------------
// mpc_cursor - cursor update and result register
// Applies the packet deltas, clamps each axis to the screen and holds the
// result until it is taken.
// ---------------------------------------------------------------------------
module mpc_cursor (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  mpc_pkg::pkt_t                 pkt,
	input  logic [7:0]                    last_byte,
	input  logic [mpc_pkg::SIZE_BITS-1:0] screen_width,
	input  logic [mpc_pkg::SIZE_BITS-1:0] screen_height,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [mpc_pkg::COORD_BITS-1:0] cursor_x,
	output logic [mpc_pkg::COORD_BITS-1:0] cursor_y,
	output logic                          plot_white,
	output logic                          plot_green
);
	import mpc_pkg::*;

	// A size of zero behaves as one; sizes past the coordinate range saturate.
	function automatic logic signed [CALC_W-1:0] axis_limit(input logic [SIZE_BITS-1:0] size);
		logic signed [CALC_W-1:0] lim;
		if (size == '0) begin
			lim = '0;
		end else begin
			lim = $signed({{(CALC_W-SIZE_BITS){1'b0}}, size}) - ONE_C;
		end
		if (lim > COORD_MAX_C) begin
			lim = COORD_MAX_C;
		end
		return lim;
	endfunction

	function automatic logic [COORD_BITS-1:0] clamp_axis(input logic signed [CALC_W-1:0] v,
			input logic signed [CALC_W-1:0] hi);
		logic [COORD_BITS-1:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > hi) begin
			r = hi[COORD_BITS-1:0];
		end else begin
			r = v[COORD_BITS-1:0];
		end
		return r;
	endfunction

	logic [COORD_BITS-1:0]    pos_x_q, pos_y_q;
	logic                     out_valid_q, white_q, green_q;
	logic signed [CALC_W-1:0] dx, dy, sum_x, sum_y;

	assign dx = $signed({{(CALC_W-8){pkt.b0[X_SIGN_BIT]}}, pkt.b1});
	assign dy = $signed({{(CALC_W-8){pkt.b0[Y_SIGN_BIT]}}, pkt.b2});

	assign sum_x = $signed({{(CALC_W-COORD_BITS){1'b0}}, pos_x_q}) + dx;
	assign sum_y = $signed({{(CALC_W-COORD_BITS){1'b0}}, pos_y_q}) - dy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q     <= '0;
			pos_y_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				pos_x_q     <= clamp_axis(sum_x, axis_limit(screen_width));
				pos_y_q     <= clamp_axis(sum_y, axis_limit(screen_height));
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			white_q <= pkt.b0[LEFT_BTN_BIT];
			green_q <= last_byte[FIFTH_BTN_BIT];
		end
	end

	// The position registers double as the result payload.
	assign out_valid  = out_valid_q;
	assign cursor_x   = pos_x_q;
	assign cursor_y   = pos_y_q;
	assign plot_white = white_q;
	assign plot_green = green_q;

`ifndef SYNTHESIS
	a_load_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!out_valid_q || out_ready))
		else $error("cursor update while an untaken result is held");

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> out_valid_q)
		else $error("result not presented after a cursor update");

	a_hold_position: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> ($stable(pos_x_q) && $stable(pos_y_q)))
		else $error("cursor moved while a result was stalled");

	a_load_on_complete: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> pkt.complete)
		else $error("cursor update without a complete packet");
`endif

endmodule
